FILE: sv/fbr_pkg.sv
// Package for the frame receiver: constants, codes and word types.
`timescale 1ns / 1ps

package fbr_pkg;

    // Frame store geometry
    localparam int STORE_DEPTH   = 64;
    localparam int STORE_AW      = $clog2(STORE_DEPTH);
    localparam int IDX_W         = 6;
    localparam int CHANNEL_BYTES = 22;
    localparam int CNT_W         = $clog2(CHANNEL_BYTES);
    localparam int CHAN_BASE     = 2;

    // Command queue between parser and emitter
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Length codes and the frame lengths they stand for
    localparam logic [7:0] LEN_CODE_8CH  = 8'h0D;
    localparam logic [7:0] LEN_CODE_16CH = 8'h18;
    localparam logic [7:0] LEN_CODE_24CH = 8'h23;
    localparam logic [7:0] LEN_CODE_POLL = 8'h08;

    localparam logic [IDX_W-1:0] FRAME_LEN_8CH  = 6'd16;
    localparam logic [IDX_W-1:0] FRAME_LEN_16CH = 6'd27;
    localparam logic [IDX_W-1:0] FRAME_LEN_24CH = 6'd38;
    localparam logic [IDX_W-1:0] FRAME_LEN_POLL = 6'd10;
    localparam logic [IDX_W-1:0] MIN_FRAME_LEN  = 6'd2;
    localparam logic [IDX_W-1:0] MAX_FRAME_LEN  = FRAME_LEN_24CH;

    localparam logic [4:0] CHANS_8  = 5'd8;
    localparam logic [4:0] CHANS_16 = 5'd16;
    localparam logic [4:0] CHANS_24 = 5'd24;

    localparam logic [7:0] TYPE_BYTE = 8'hFF;
    localparam logic [7:0] SUM_OK    = 8'hFF;
    localparam logic [7:0] POLL_PRIM = 8'h10;

    localparam logic [IDX_W-1:0] IDX_TYPE    = 6'd1;
    localparam logic [IDX_W-1:0] IDX_DEV_ID  = 6'd1;
    localparam logic [IDX_W-1:0] IDX_PRIM    = 6'd2;
    localparam logic [IDX_W-1:0] IDX_FLAGS   = 6'd24;
    localparam int               FLAG_MISSING = 2;
    localparam int               FLAG_FSAFE   = 3;

    // Result kinds
    localparam logic [2:0] KIND_CHAN       = 3'd0;
    localparam logic [2:0] KIND_POLL_US    = 3'd1;
    localparam logic [2:0] KIND_DOWN_OTHER = 3'd2;
    localparam logic [2:0] KIND_BAD_LEN    = 3'd3;
    localparam logic [2:0] KIND_BAD_TYPE   = 3'd4;
    localparam logic [2:0] KIND_BAD_SUM    = 3'd5;
    localparam logic [2:0] KIND_BAD_CHANS  = 3'd6;

    // Emitter actions carried by a command
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_SINGLE  = 2'd1;
    localparam logic [1:0] ACT_READOUT = 2'd2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       gap_before;
    } t_in_word;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] channel_byte;
        logic       signal_missing;
        logic       failsafe;
        logic       last;
    } t_out_word;

    // One command per accepted byte: optional store write plus an action
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [7:0]       wr_data;
        logic [1:0]       act;
        logic [2:0]       kind;
        logic             missing;
        logic             failsafe;
    } t_cmd;

endpackage

FILE: sv/fbr_front.sv
// Parser front end: tracks frame position and checksum, issues emitter commands.
`timescale 1ns / 1ps

module fbr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fbr_pkg::t_in_word i_in_word,
    input  logic [7:0]        i_device_id,
    input  logic              i_queue_full,
    output logic              o_push,
    output fbr_pkg::t_cmd     o_cmd
);

    logic [fbr_pkg::IDX_W-1:0] r_byte_index, n_byte_index;
    logic [fbr_pkg::IDX_W-1:0] r_exp_len, n_exp_len;
    logic                      r_is_dl, n_is_dl;
    logic [4:0]                r_chan_cnt, n_chan_cnt;
    logic [7:0]                r_sum, n_sum;
    // captured store bytes needed at frame end
    logic [7:0]                r_dev_byte;
    logic                      r_prim_ok;
    logic [1:0]                r_flags;

    logic                      accept;
    logic [fbr_pkg::IDX_W-1:0] idx;
    logic [fbr_pkg::IDX_W-1:0] idx_inc;
    logic [8:0]                sum_wide;
    logic [7:0]                sum_fold;
    logic [7:0]                rx;
    fbr_pkg::t_cmd             cmd;

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept;
    assign o_cmd      = cmd;
    assign rx         = i_in_word.rx_byte;

    // end-around carry sum
    assign sum_wide = {1'b0, r_sum} + {1'b0, rx};
    assign sum_fold = sum_wide[7:0] + {7'd0, sum_wide[8]};

    assign idx     = i_in_word.gap_before ? '0 : r_byte_index;
    assign idx_inc = idx + 6'd1;

    // Next state and command for the byte on the input
    always_comb begin
        n_byte_index = idx;
        n_exp_len    = r_exp_len;
        n_is_dl      = r_is_dl;
        n_chan_cnt   = r_chan_cnt;
        n_sum        = r_sum;
        cmd          = '0;
        cmd.wr_addr  = idx;
        cmd.wr_data  = rx;
        cmd.act      = fbr_pkg::ACT_NONE;

        priority if (idx == '0) begin
            cmd.wr_en    = 1'b1;
            n_sum        = '0;
            n_byte_index = idx_inc;
            unique case (rx)
                fbr_pkg::LEN_CODE_8CH: begin
                    n_exp_len  = fbr_pkg::FRAME_LEN_8CH;
                    n_chan_cnt = fbr_pkg::CHANS_8;
                    n_is_dl    = 1'b0;
                end
                fbr_pkg::LEN_CODE_16CH: begin
                    n_exp_len  = fbr_pkg::FRAME_LEN_16CH;
                    n_chan_cnt = fbr_pkg::CHANS_16;
                    n_is_dl    = 1'b0;
                end
                fbr_pkg::LEN_CODE_24CH: begin
                    n_exp_len  = fbr_pkg::FRAME_LEN_24CH;
                    n_chan_cnt = fbr_pkg::CHANS_24;
                    n_is_dl    = 1'b0;
                end
                fbr_pkg::LEN_CODE_POLL: begin
                    n_exp_len = fbr_pkg::FRAME_LEN_POLL;
                    n_is_dl   = 1'b1;
                end
                default: begin
                    // unknown length code: drop byte, keep waiting
                    cmd.wr_en    = 1'b0;
                    cmd.act      = fbr_pkg::ACT_SINGLE;
                    cmd.kind     = fbr_pkg::KIND_BAD_LEN;
                    n_sum        = r_sum;
                    n_byte_index = '0;
                end
            endcase
        end else if (idx == fbr_pkg::IDX_TYPE && !r_is_dl && rx != fbr_pkg::TYPE_BYTE) begin
            cmd.act      = fbr_pkg::ACT_SINGLE;
            cmd.kind     = fbr_pkg::KIND_BAD_TYPE;
            n_byte_index = '0;
        end else begin
            cmd.wr_en    = 1'b1;
            n_sum        = sum_fold;
            n_byte_index = idx_inc;
            // frame end check
            if (n_exp_len > fbr_pkg::MIN_FRAME_LEN && idx_inc == n_exp_len) begin
                n_byte_index = '0;
                cmd.act      = fbr_pkg::ACT_SINGLE;
                priority if (sum_fold != fbr_pkg::SUM_OK) begin
                    cmd.kind = fbr_pkg::KIND_BAD_SUM;
                end else if (r_is_dl) begin
                    cmd.kind = (r_dev_byte == i_device_id && r_prim_ok)
                             ? fbr_pkg::KIND_POLL_US : fbr_pkg::KIND_DOWN_OTHER;
                end else if (r_chan_cnt != fbr_pkg::CHANS_16) begin
                    cmd.kind = fbr_pkg::KIND_BAD_CHANS;
                end else begin
                    cmd.act      = fbr_pkg::ACT_READOUT;
                    cmd.kind     = fbr_pkg::KIND_CHAN;
                    cmd.missing  = r_flags[0];
                    cmd.failsafe = r_flags[1];
                end
            end
        end

        // writes beyond the store are dropped
        if (32'(idx) >= fbr_pkg::STORE_DEPTH) begin
            cmd.wr_en = 1'b0;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
            r_exp_len    <= '0;
            r_is_dl      <= 1'b0;
            r_chan_cnt   <= '0;
            r_sum        <= '0;
        end else if (accept) begin
            r_byte_index <= n_byte_index;
            r_exp_len    <= n_exp_len;
            r_is_dl      <= n_is_dl;
            r_chan_cnt   <= n_chan_cnt;
            r_sum        <= n_sum;
        end
    end

    // Shadow copies of the store bytes checked at frame end
    always_ff @(posedge i_clk) begin
        if (accept && cmd.wr_en) begin
            if (idx == fbr_pkg::IDX_DEV_ID) begin
                r_dev_byte <= rx;
            end
            if (idx == fbr_pkg::IDX_PRIM) begin
                r_prim_ok <= (rx == fbr_pkg::POLL_PRIM);
            end
            if (idx == fbr_pkg::IDX_FLAGS) begin
                r_flags <= {rx[fbr_pkg::FLAG_FSAFE], rx[fbr_pkg::FLAG_MISSING]};
            end
        end
    end

    // Position never runs past the longest frame
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_index < fbr_pkg::MAX_FRAME_LEN)
        else $error("byte index past longest frame");

endmodule

FILE: sv/fbr_queue.sv
// Small command FIFO between the parser and the emitter.
`timescale 1ns / 1ps

module fbr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fbr_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output fbr_pkg::t_cmd o_cmd
);

    fbr_pkg::t_cmd r_slot [fbr_pkg::QUEUE_DEPTH];
    logic [fbr_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [fbr_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [fbr_pkg::QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (fbr_pkg::QUEUE_AW+1)'(fbr_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + fbr_pkg::QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + fbr_pkg::QUEUE_AW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (fbr_pkg::QUEUE_AW+1)'(1);
                2'b01:   r_count <= r_count - (fbr_pkg::QUEUE_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: sv/fbr_back.sv
// Emitter back end: owns the frame store and drives result words.
`timescale 1ns / 1ps

module fbr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  fbr_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fbr_pkg::t_out_word o_out_word
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_SEND = 2'd2;

    logic [7:0]                   r_mem [fbr_pkg::STORE_DEPTH];
    logic [7:0]                   r_rd_data;
    logic [fbr_pkg::STORE_AW-1:0] rd_addr;

    logic [1:0]                r_state, n_state;
    logic [fbr_pkg::CNT_W-1:0] r_k, n_k;
    logic                      r_missing;
    logic                      r_failsafe;
    logic                      r_out_valid;
    fbr_pkg::t_out_word        r_out_word, n_out_word;
    logic                      out_free;
    logic                      out_load;
    logic                      k_last;

    assign out_free = !r_out_valid || i_out_ready;
    assign k_last   = (r_k == fbr_pkg::CNT_W'(fbr_pkg::CHANNEL_BYTES - 1));
    assign rd_addr  = fbr_pkg::STORE_AW'(fbr_pkg::CHAN_BASE) + fbr_pkg::STORE_AW'(r_k);

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Pop when idle; a command with a single result word waits for the output slot
    assign o_cmd_pop = i_cmd_valid && (r_state == ST_IDLE)
                    && (i_cmd.act != fbr_pkg::ACT_SINGLE || out_free);

    // Frame store: written in command order, read data registered
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd.wr_en) begin
            r_mem[fbr_pkg::STORE_AW'(i_cmd.wr_addr)] <= i_cmd.wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Readout sequencer
    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        out_load   = 1'b0;
        n_out_word = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd_pop) begin
                    if (i_cmd.act == fbr_pkg::ACT_SINGLE) begin
                        out_load        = 1'b1;
                        n_out_word.kind = i_cmd.kind;
                        n_out_word.last = 1'b1;
                    end else if (i_cmd.act == fbr_pkg::ACT_READOUT) begin
                        n_state = ST_READ;
                        n_k     = '0;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_SEND;
            end
            ST_SEND: begin
                if (out_free) begin
                    out_load                  = 1'b1;
                    n_out_word.kind           = fbr_pkg::KIND_CHAN;
                    n_out_word.channel_byte   = r_rd_data;
                    n_out_word.signal_missing = r_missing;
                    n_out_word.failsafe       = r_failsafe;
                    n_out_word.last           = k_last;
                    n_k                       = r_k + fbr_pkg::CNT_W'(1);
                    n_state                   = k_last ? ST_IDLE : ST_READ;
                    if (k_last) begin
                        n_k = '0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output word and readout flags
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_word <= n_out_word;
        end
        if (o_cmd_pop && i_cmd.act == fbr_pkg::ACT_READOUT) begin
            r_missing  <= i_cmd.missing;
            r_failsafe <= i_cmd.failsafe;
        end
    end

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= fbr_pkg::CNT_W'(fbr_pkg::CHANNEL_BYTES - 1))
        else $error("readout counter out of range");

    a_only_chan_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_word.last) |-> (r_out_word.kind == fbr_pkg::KIND_CHAN))
        else $error("non-final word that is not a channel byte");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out_word)))
        else $error("stalled result word changed");

endmodule

FILE: sv/fbus_frame_receiver.sv
// Top level of the bus frame receiver: device id register and front/queue/back.
//
// Input channel (i_in_valid / o_in_ready / i_in_word) takes one received word per
// cycle: the byte and a flag that marks a line gap before it. A gap restarts the
// frame. Each word enters a 4-entry command queue, so the input stalls only when
// that queue is full.
// Output channel (o_out_valid / i_out_ready / o_out_word) gives result words. An
// error, a poll or a rejected frame gives one word with last set, after its
// command passes the queue and the output register. A good 16-channel frame gives
// 22 channel words; for each word the emitter reads the store, then loads the
// output register. Mid-frame bytes occupy the emitter only for the store write.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the device id;
// it is always ready.
// Reset clears parser position, checksum, queue and output valid; the device id
// returns to 0. The frame store needs no clearing pass.
// When the receiver holds i_out_ready low, the output word holds, the emitter
// stops at its next result word, and the queue fills until the input stalls.
`timescale 1ns / 1ps

module fbus_frame_receiver (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fbr_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fbr_pkg::t_out_word o_out_word,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data
);

    logic [7:0]    r_device_id;
    logic          push;
    logic          queue_full;
    logic          pop;
    logic          cmd_valid;
    fbr_pkg::t_cmd front_cmd;
    fbr_pkg::t_cmd back_cmd;

    assign o_cfg_ready = 1'b1;

    // Device id register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_device_id <= i_cfg_data;
        end
    end

    fbr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .i_device_id  (r_device_id),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    fbr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (cmd_valid),
        .o_cmd   (back_cmd)
    );

    fbr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (back_cmd),
        .o_cmd_pop   (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
